/* hdl/lpht_pkg.sv */
// Shared types, codes and the control program of the linear probe hash table.
`default_nettype none

package lpht_pkg;

  localparam int TABLE_SIZE_DEF = 16;
  localparam int KEY_W          = 31;
  localparam int DIV_W          = 5;
  localparam int SLOT_W         = 4;
  localparam int REQ_W          = 2;

  localparam logic [DIV_W-1:0] DIVISOR_RST = 5'd11;
  localparam logic [DIV_W-1:0] DIV_LAST    = 5'(KEY_W - 1);

  typedef logic [REQ_W-1:0] req_t;
  localparam req_t RQ_INSERT = 2'd0;
  localparam req_t RQ_REMOVE = 2'd1;
  localparam req_t RQ_LOOKUP = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_EMPTY   = 2'd0;
  localparam status_t ST_LIVE    = 2'd1;
  localparam status_t ST_DELETED = 2'd2;

  typedef logic [2:0] step_t;
  localparam step_t S_CLR   = 3'd0;
  localparam step_t S_IDLE  = 3'd1;
  localparam step_t S_DISP  = 3'd2;
  localparam step_t S_DIV   = 3'd3;
  localparam step_t S_WRAP  = 3'd4;
  localparam step_t S_READ  = 3'd5;
  localparam step_t S_CHECK = 3'd6;
  localparam step_t S_ACT   = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DIV,
    OP_WRAP,
    OP_READ,
    OP_CHECK,
    OP_ACT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CLR_MORE,
    C_ACCEPT,
    C_BAD_REQ,
    C_DIV_MORE,
    C_WRAP_MORE,
    C_PROBE_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  // Control store: one word per step, branch to tgt_t when cond holds.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      S_CLR:   w = '{OP_CLEAR, C_CLR_MORE,   S_CLR,   S_IDLE};
      S_IDLE:  w = '{OP_LOAD,  C_ACCEPT,     S_DISP,  S_IDLE};
      S_DISP:  w = '{OP_NONE,  C_BAD_REQ,    S_ACT,   S_DIV};
      S_DIV:   w = '{OP_DIV,   C_DIV_MORE,   S_DIV,   S_WRAP};
      S_WRAP:  w = '{OP_WRAP,  C_WRAP_MORE,  S_WRAP,  S_READ};
      S_READ:  w = '{OP_READ,  C_ALWAYS,     S_CHECK, S_CHECK};
      S_CHECK: w = '{OP_CHECK, C_PROBE_MORE, S_READ,  S_ACT};
      S_ACT:   w = '{OP_ACT,   C_OUT_BUSY,   S_ACT,   S_IDLE};
      default: w = '{OP_NONE,  C_ALWAYS,     S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/linear_probe_hash_table.sv */
// Linear probe hash table: microcoded sequencer, key and status stores, result register.
// Sequence: accept, dispatch, bit-serial remainder steps over the key, wrap steps that
//   subtract TABLE_SIZE while the remainder is at least TABLE_SIZE, a read and a check per
//   probed slot (1 to TABLE_SIZE slots), then the action step; an unknown type skips to it.
// One request at a time: no new request is taken until the action step is done; a stalled result holds it.
// Reset: synchronous, active low; divisor to 11, then the status store is cleared slot by slot with stall.
`default_nettype none

module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // configuration: divisor register
  input  wire                          cfg_we,
  input  wire  [lpht_pkg::DIV_W-1:0]   cfg_wdata,
  // request channel
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [lpht_pkg::REQ_W-1:0]   in_req_type,
  input  wire  [lpht_pkg::KEY_W-1:0]   in_key,
  // result channel
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_ok,
  output logic [lpht_pkg::SLOT_W-1:0]  out_slot
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  // compare width wide enough for both the 5-bit remainder and TABLE_SIZE
  localparam int CW    = (IDX_W + 1 > DIV_W + 1) ? IDX_W + 1 : DIV_W + 1;

  typedef logic [IDX_W-1:0] idx_t;

  // slot stores
  logic [KEY_W-1:0] key_mem [TABLE_SIZE];
  status_t          st_mem  [TABLE_SIZE];

  // sequencer and datapath registers
  step_t            upc_r,      upc_nxt;
  logic [DIV_W-1:0] divisor_r,  divisor_nxt;
  idx_t             clr_cnt_r,  clr_cnt_nxt;
  req_t             req_r,      req_nxt;
  logic [KEY_W-1:0] key_r,      key_nxt;
  logic [KEY_W-1:0] div_sh_r,   div_sh_nxt;
  logic [DIV_W-1:0] d_r,        d_nxt;
  logic [DIV_W-1:0] rem_r,      rem_nxt;
  logic [DIV_W-1:0] cnt_r,      cnt_nxt;
  idx_t             idx_r,      idx_nxt;
  idx_t             home_r,     home_nxt;
  idx_t             pos_r,      pos_nxt;
  logic             first_r,    first_nxt;
  logic             found_r,    found_nxt;
  status_t          home_st_r,  home_st_nxt;
  status_t          stop_st_r,  stop_st_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r,   out_ok_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;

  // registered read data of the slot stores
  logic [KEY_W-1:0] rd_key_r;
  status_t          rd_st_r;

  // store write port
  logic             st_we;
  idx_t             st_wa;
  status_t          st_wd;
  logic             key_we;
  logic             rd_en;

  uword_t           uw;
  logic             cond_true;
  logic             in_accept;
  logic             out_busy;
  logic [DIV_W:0]   div_trial;
  logic [CW-1:0]    rem_ext;
  logic             wrap_more;
  logic             hit;
  logic             empty;
  idx_t             idx_inc;
  logic             probe_more;

  assign uw        = ucode(upc_r);
  assign in_stall  = (upc_r != S_IDLE);
  assign in_accept = in_valid && (upc_r == S_IDLE);
  assign out_busy  = out_valid_r && out_stall;

  // shift in the next key bit over the partial remainder
  assign div_trial = {rem_r, div_sh_r[KEY_W-1]};
  assign rem_ext   = CW'(rem_r);
  assign wrap_more = (rem_ext >= CW'(TABLE_SIZE));

  // probe decision on the slot just read
  assign hit        = (rd_st_r == ST_LIVE) && (rd_key_r == key_r);
  assign empty      = (rd_st_r == ST_EMPTY);
  assign idx_inc    = (idx_r == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_r + 1'b1;
  assign probe_more = !hit && !empty && (idx_inc != home_r);

  always_comb begin
    upc_nxt       = upc_r;
    divisor_nxt   = divisor_r;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    div_sh_nxt    = div_sh_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    home_nxt      = home_r;
    pos_nxt       = pos_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    home_st_nxt   = home_st_r;
    stop_st_nxt   = stop_st_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    st_we         = 1'b0;
    st_wa         = clr_cnt_r;
    st_wd         = ST_EMPTY;
    key_we        = 1'b0;
    rd_en         = 1'b0;
    cond_true     = 1'b0;

    if (cfg_we) begin
      divisor_nxt = cfg_wdata;
    end

    // drop the result once the consumer takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (uw.op)
      OP_CLEAR: begin
        st_we       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      OP_LOAD: begin
        if (in_accept) begin
          req_nxt     = in_req_type;
          key_nxt     = in_key;
          div_sh_nxt  = in_key;
          d_nxt       = (divisor_r == '0) ? DIV_W'(1) : divisor_r;
          rem_nxt     = '0;
          cnt_nxt     = '0;
          pos_nxt     = '0;
          found_nxt   = 1'b0;
          stop_st_nxt = ST_EMPTY;
        end
      end
      OP_DIV: begin
        if (div_trial >= {1'b0, d_r}) begin
          rem_nxt = DIV_W'(div_trial - {1'b0, d_r});
        end else begin
          rem_nxt = div_trial[DIV_W-1:0];
        end
        div_sh_nxt = {div_sh_r[KEY_W-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
      end
      OP_WRAP: begin
        if (wrap_more) begin
          rem_nxt = DIV_W'(rem_ext - CW'(TABLE_SIZE));
        end else begin
          idx_nxt   = IDX_W'(rem_r);
          home_nxt  = IDX_W'(rem_r);
          first_nxt = 1'b1;
        end
      end
      OP_READ: begin
        rd_en = 1'b1;
      end
      OP_CHECK: begin
        first_nxt = 1'b0;
        if (first_r) begin
          home_st_nxt = rd_st_r;
        end
        if (hit || empty) begin
          pos_nxt     = idx_r;
          found_nxt   = hit;
          stop_st_nxt = rd_st_r;
        end else if (idx_inc == home_r) begin
          // full lap: stop at home
          pos_nxt     = home_r;
          found_nxt   = 1'b0;
          stop_st_nxt = first_r ? rd_st_r : home_st_r;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      OP_ACT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = SLOT_W'(pos_r);
          out_ok_nxt    = 1'b0;
          st_wa         = pos_r;
          case (req_r)
            RQ_INSERT: begin
              if (!found_r && (stop_st_r != ST_LIVE)) begin
                out_ok_nxt = 1'b1;
                key_we     = 1'b1;
                st_we      = 1'b1;
                st_wd      = ST_LIVE;
              end
            end
            RQ_REMOVE: begin
              if (found_r) begin
                out_ok_nxt = 1'b1;
                st_we      = 1'b1;
                st_wd      = ST_DELETED;
              end
            end
            RQ_LOOKUP: begin
              out_ok_nxt = found_r;
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    case (uw.cond)
      C_ALWAYS:     cond_true = 1'b1;
      C_CLR_MORE:   cond_true = (clr_cnt_r != IDX_W'(TABLE_SIZE - 1));
      C_ACCEPT:     cond_true = in_accept;
      C_BAD_REQ:    cond_true = (req_r != RQ_INSERT) && (req_r != RQ_REMOVE) &&
                                (req_r != RQ_LOOKUP);
      C_DIV_MORE:   cond_true = (cnt_r != DIV_LAST);
      C_WRAP_MORE:  cond_true = wrap_more;
      C_PROBE_MORE: cond_true = probe_more;
      C_OUT_BUSY:   cond_true = out_busy;
      default:      cond_true = 1'b0;
    endcase

    upc_nxt = cond_true ? uw.tgt_t : uw.tgt_f;
  end

  // slot stores: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    if (key_we) begin
      key_mem[pos_r] <= key_r;
    end
    if (rd_en) begin
      rd_st_r  <= st_mem[idx_r];
      rd_key_r <= key_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_CLR;
      divisor_r   <= DIVISOR_RST;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      divisor_r   <= divisor_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    div_sh_r   <= div_sh_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    home_r     <= home_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    home_st_r  <= home_st_nxt;
    stop_st_r  <= stop_st_nxt;
    out_ok_r   <= out_ok_nxt;
    out_slot_r <= out_slot_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_slot  = out_slot_r;

  // the divisor in use is never zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_DIV) |-> (d_r != '0))
    else $error("zero divisor in remainder loop");

  // partial remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_DIV) |-> (rem_r < d_r))
    else $error("partial remainder out of range");

  // home slot lies inside the table once probing starts
  a_home_range: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_READ) |-> (CW'(home_r) < CW'(TABLE_SIZE)))
    else $error("home slot beyond table");

  // a result appears only from the action step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(upc_r == S_ACT))
    else $error("result raised outside action step");

endmodule

`default_nettype wire
